// ===== hw/rtl/sicxe_pkg.sv =====
// Shared types and constants for the SIC/XE instruction executor.
// Depends on nothing; the datapath, controller, top level and checker import it.
package sicxe_pkg;

    localparam int MEM_ADDR_BITS = 16;
    localparam int WORD_BITS     = 24;
    localparam int MEM_DEPTH     = 1 << MEM_ADDR_BITS;
    localparam int CFG_BITS      = 20;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_STEP  = 2'd2;

    localparam logic CFG_START = 1'b0;
    localparam logic CFG_END   = 1'b1;

    typedef enum logic [1:0] {
        ASEL_ITEM = 2'd0,
        ASEL_PC   = 2'd1,
        ASEL_TA   = 2'd2
    } addr_sel_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] mem_address;
        logic [7:0]  write_byte;
    } in_item_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] reg_a;
        logic [WORD_BITS-1:0] reg_x;
        logic [WORD_BITS-1:0] reg_l;
        logic [WORD_BITS-1:0] reg_b;
        logic [WORD_BITS-1:0] reg_s;
        logic [WORD_BITS-1:0] reg_t;
        logic [WORD_BITS-1:0] program_counter;
        logic [1:0]           condition_code;
        logic                 program_ended;
        logic [7:0]           read_byte;
    } out_item_t;

    typedef struct packed {
        logic       mem_we;
        addr_sel_t  asel;
        logic [1:0] off;
        logic       ld_item;
        logic       cap_rbyte;
        logic       cap_byte;
        logic [1:0] cap_idx;
        logic       ld_npc;
        logic       ld_adr1;
        logic       ld_adr2;
        logic       shift_word;
        logic       ta_from_word;
        logic       do_exec;
        logic       do_end;
        logic       ld_out;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       fmt2;
        logic       ext;
        logic       ind;
        logic       need_word;
        logic       store3;
        logic       store1;
    } dp_status_t;

endpackage

// ===== hw/rtl/sicxe_ram.sv =====
// Generic single-port RAM with registered read data.
// Depends on nothing.
module sicxe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== hw/rtl/sicxe_dp.sv =====
// Datapath: register file, instruction bytes, address arithmetic, memory and result register.
// Depends on sicxe_pkg and sicxe_ram.
module sicxe_dp (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sicxe_pkg::in_item_t    in_data,
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic [19:0]            cfg_data,
    input  sicxe_pkg::dp_cmd_t     cmd,
    output sicxe_pkg::dp_status_t  status,
    output sicxe_pkg::out_item_t   out_data
);
    import sicxe_pkg::*;

    localparam logic [7:0] OP_LDA   = 8'h00;
    localparam logic [7:0] OP_LDB   = 8'h68;
    localparam logic [7:0] OP_LDT   = 8'h74;
    localparam logic [7:0] OP_LDCH  = 8'h50;
    localparam logic [7:0] OP_STA   = 8'h0C;
    localparam logic [7:0] OP_STX   = 8'h10;
    localparam logic [7:0] OP_STL   = 8'h14;
    localparam logic [7:0] OP_STCH  = 8'h54;
    localparam logic [7:0] OP_J     = 8'h3C;
    localparam logic [7:0] OP_JSUB  = 8'h48;
    localparam logic [7:0] OP_JLT   = 8'h38;
    localparam logic [7:0] OP_JEQ   = 8'h30;
    localparam logic [7:0] OP_RSUB  = 8'h4C;
    localparam logic [7:0] OP_COMP  = 8'h28;
    localparam logic [7:0] OP_COMPR = 8'hA0;
    localparam logic [7:0] OP_CLEAR = 8'hB4;
    localparam logic [7:0] OP_TIXR  = 8'hB8;
    localparam logic [7:0] OP_TD    = 8'hE0;
    localparam logic [7:0] OP_RD    = 8'hD8;

    localparam logic [3:0] R_A  = 4'd0;
    localparam logic [3:0] R_X  = 4'd1;
    localparam logic [3:0] R_L  = 4'd2;
    localparam logic [3:0] R_B  = 4'd3;
    localparam logic [3:0] R_S  = 4'd4;
    localparam logic [3:0] R_T  = 4'd5;
    localparam logic [3:0] R_PC = 4'd8;
    localparam logic [3:0] R_SW = 4'd9;

    localparam logic [1:0] CC_LT = 2'd0;
    localparam logic [1:0] CC_EQ = 2'd1;
    localparam logic [1:0] CC_GT = 2'd2;

    logic [WORD_BITS-1:0] a_reg, x_reg, l_reg, b_reg, s_reg, t_reg, pc_reg;
    logic [WORD_BITS-1:0] a_next, x_next, l_next, b_next, s_next, t_next, pc_next;
    logic [1:0]           sw_reg, sw_next;
    logic [19:0]          start_reg, end_reg;
    in_item_t             item_reg;
    logic [7:0]           ib0_reg, ib1_reg, ib2_reg, ib3_reg;
    logic [WORD_BITS-1:0] ta_reg, npc_reg, word_reg;
    logic [7:0]           rbyte_reg;
    logic                 ended_reg;
    out_item_t            out_reg;

    logic [7:0]               rdata;
    logic [7:0]               op;
    logic                     fmt2, imm;
    logic [19:0]              disp;
    logic                     neg;
    logic [WORD_BITS-1:0]     rel_off, adr1_ta, base_addr, addr_sum, val;
    logic [MEM_ADDR_BITS-1:0] ram_addr;
    logic [7:0]               ram_wdata, store_byte;
    logic [WORD_BITS-1:0]     store_word;
    logic [19:0]              idx_hi;
    logic                     hi_ok;
    logic [WORD_BITS-1:0]     x_inc;

    function automatic logic [1:0] cmp_code(input logic [WORD_BITS-1:0] lhs,
                                            input logic [WORD_BITS-1:0] rhs);
        logic [1:0] c;
        if (lhs < rhs)
        begin
            c = CC_LT;
        end
        else if (lhs == rhs)
        begin
            c = CC_EQ;
        end
        else
        begin
            c = CC_GT;
        end
        return c;
    endfunction

    // Register read by number; numbers that name no register read zero.
    function automatic logic [WORD_BITS-1:0] rget(input logic [3:0] idx,
                                                  input logic [WORD_BITS-1:0] xv);
        logic [WORD_BITS-1:0] v;
        unique case (idx)
            R_A:     v = a_reg;
            R_X:     v = xv;
            R_L:     v = l_reg;
            R_B:     v = b_reg;
            R_S:     v = s_reg;
            R_T:     v = t_reg;
            R_PC:    v = npc_reg;
            R_SW:    v = {{(WORD_BITS-2){1'b0}}, sw_reg};
            default: v = '0;
        endcase
        return v;
    endfunction

    // Decode
    assign fmt2 = (ib0_reg == OP_COMPR) || (ib0_reg == OP_CLEAR) || (ib0_reg == OP_TIXR);
    assign op   = fmt2 ? ib0_reg : (ib0_reg & 8'hFC);
    assign imm  = !fmt2 && !ib0_reg[1] && ib0_reg[0];
    assign disp = ib1_reg[4] ? {ib1_reg[3:0], ib2_reg, ib3_reg}
                             : {8'h00, ib1_reg[3:0], ib2_reg};
    // A PC-relative field from 0x800 to 0xFFF is a negative 12-bit offset.
    assign neg     = (disp[19:11] == 9'd1);
    assign rel_off = neg ? {{(WORD_BITS-12){1'b1}}, disp[11:0]}
                         : {{(WORD_BITS-20){1'b0}}, disp};

    always_comb
    begin
        if (ib1_reg[6])
        begin
            adr1_ta = b_reg + {{(WORD_BITS-20){1'b0}}, disp};
        end
        else if (ib1_reg[5])
        begin
            adr1_ta = npc_reg + rel_off;
        end
        else
        begin
            adr1_ta = {{(WORD_BITS-20){1'b0}}, disp};
        end
    end

    assign status.kind      = item_reg.opcode;
    assign status.fmt2      = fmt2;
    assign status.ext       = ib1_reg[4];
    assign status.ind       = !fmt2 && ib0_reg[1] && !ib0_reg[0];
    assign status.need_word = !imm && ((op == OP_LDA) || (op == OP_LDB) || (op == OP_LDT)
                              || (op == OP_COMP) || (op == OP_LDCH));
    assign status.store3    = (op == OP_STA) || (op == OP_STX) || (op == OP_STL);
    assign status.store1    = (op == OP_STCH);

    // Memory port
    always_comb
    begin
        case (cmd.asel)
            ASEL_PC:  base_addr = pc_reg;
            ASEL_TA:  base_addr = ta_reg;
            default:  base_addr = '0;
        endcase
    end
    assign addr_sum = base_addr + {{(WORD_BITS-2){1'b0}}, cmd.off};

    always_comb
    begin
        if (op == OP_STA)
        begin
            store_word = a_reg;
        end
        else if (op == OP_STX)
        begin
            store_word = x_reg;
        end
        else
        begin
            store_word = l_reg;
        end
        case (cmd.off)
            2'd0:    store_byte = store_word[23:16];
            2'd1:    store_byte = store_word[15:8];
            default: store_byte = store_word[7:0];
        endcase
        if (cmd.asel == ASEL_ITEM)
        begin
            ram_addr  = MEM_ADDR_BITS'(item_reg.mem_address);
            ram_wdata = item_reg.write_byte;
        end
        else
        begin
            ram_addr  = addr_sum[MEM_ADDR_BITS-1:0];
            ram_wdata = status.store1 ? a_reg[7:0] : store_byte;
        end
    end

    sicxe_ram #(
        .WIDTH (8),
        .DEPTH (MEM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.mem_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (rdata)
    );

    // Execute
    assign val    = imm ? ta_reg : word_reg;
    assign idx_hi = ta_reg[23:4];
    assign hi_ok  = (idx_hi[19:4] == 16'd0);
    assign x_inc  = x_reg + {{(WORD_BITS-1){1'b0}}, 1'b1};

    always_comb
    begin
        a_next  = a_reg;
        x_next  = x_reg;
        l_next  = l_reg;
        b_next  = b_reg;
        s_next  = s_reg;
        t_next  = t_reg;
        pc_next = npc_reg;
        sw_next = sw_reg;
        unique case (op)
            OP_LDA:  a_next = val;
            OP_LDB:  b_next = val;
            OP_LDT:  t_next = val;
            OP_LDCH: a_next = {a_reg[23:8], imm ? ta_reg[7:0] : word_reg[23:16]};
            OP_J:    pc_next = ta_reg;
            OP_JSUB:
            begin
                l_next  = npc_reg;
                pc_next = ta_reg;
            end
            OP_JLT:
            begin
                if (sw_reg == CC_LT)
                begin
                    pc_next = ta_reg;
                end
            end
            OP_JEQ:
            begin
                if (sw_reg == CC_EQ)
                begin
                    pc_next = ta_reg;
                end
            end
            OP_RSUB: pc_next = l_reg;
            OP_COMP: sw_next = cmp_code(a_reg, val);
            OP_COMPR:
            begin
                sw_next = cmp_code(hi_ok ? rget(idx_hi[3:0], x_reg) : '0,
                                   rget(ta_reg[3:0], x_reg));
            end
            OP_CLEAR:
            begin
                if (hi_ok)
                begin
                    unique case (idx_hi[3:0])
                        R_A:     a_next  = '0;
                        R_X:     x_next  = '0;
                        R_L:     l_next  = '0;
                        R_B:     b_next  = '0;
                        R_S:     s_next  = '0;
                        R_T:     t_next  = '0;
                        R_PC:    pc_next = '0;
                        R_SW:    sw_next = CC_LT;
                        default: ;
                    endcase
                end
            end
            OP_TIXR:
            begin
                x_next  = x_inc;
                sw_next = cmp_code(x_inc, hi_ok ? rget(idx_hi[3:0], x_inc) : '0);
            end
            OP_TD:   sw_next = CC_LT;
            OP_RD:   a_next = {8'h00, a_reg[23:8]};
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg     <= '0;
            x_reg     <= '0;
            l_reg     <= '0;
            b_reg     <= '0;
            s_reg     <= '0;
            t_reg     <= '0;
            pc_reg    <= '0;
            sw_reg    <= '0;
            start_reg <= '0;
            end_reg   <= 20'hFFFFF;
            rbyte_reg <= '0;
            ended_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_START: start_reg <= cfg_data;
                    CFG_END:   end_reg   <= cfg_data;
                    default:   ;
                endcase
            end
            if (cmd.ld_item)
            begin
                rbyte_reg <= '0;
                ended_reg <= 1'b0;
            end
            if (cmd.cap_rbyte)
            begin
                rbyte_reg <= rdata;
            end
            if (cmd.do_exec)
            begin
                a_reg  <= a_next;
                x_reg  <= x_next;
                l_reg  <= l_next;
                b_reg  <= b_next;
                s_reg  <= s_next;
                t_reg  <= t_next;
                pc_reg <= pc_next;
                sw_reg <= sw_next;
            end
            // Reaching the end address restarts the program.
            if (cmd.do_end && (pc_reg == {{(WORD_BITS-20){1'b0}}, end_reg}))
            begin
                a_reg     <= '0;
                x_reg     <= '0;
                b_reg     <= '0;
                s_reg     <= '0;
                t_reg     <= '0;
                sw_reg    <= '0;
                pc_reg    <= {{(WORD_BITS-20){1'b0}}, start_reg};
                l_reg     <= {{(WORD_BITS-20){1'b0}}, end_reg};
                ended_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld_item)
        begin
            item_reg <= in_data;
        end
        if (cmd.cap_byte)
        begin
            case (cmd.cap_idx)
                2'd0:    ib0_reg <= rdata;
                2'd1:    ib1_reg <= rdata;
                2'd2:    ib2_reg <= rdata;
                default: ib3_reg <= rdata;
            endcase
        end
        if (cmd.ld_npc)
        begin
            npc_reg <= pc_reg + (ib1_reg[4] ? WORD_BITS'(4) : WORD_BITS'(3));
        end
        if (cmd.ld_adr1)
        begin
            if (fmt2)
            begin
                ta_reg  <= {{(WORD_BITS-8){1'b0}}, ib1_reg};
                npc_reg <= pc_reg + WORD_BITS'(2);
            end
            else
            begin
                ta_reg <= adr1_ta;
            end
        end
        if (cmd.ld_adr2 && ib1_reg[7])
        begin
            ta_reg <= ta_reg + x_reg;
        end
        if (cmd.shift_word)
        begin
            word_reg <= {word_reg[15:0], rdata};
        end
        if (cmd.ta_from_word)
        begin
            ta_reg <= word_reg;
        end
        if (cmd.ld_out)
        begin
            out_reg.reg_a           <= a_reg;
            out_reg.reg_x           <= x_reg;
            out_reg.reg_l           <= l_reg;
            out_reg.reg_b           <= b_reg;
            out_reg.reg_s           <= s_reg;
            out_reg.reg_t           <= t_reg;
            out_reg.program_counter <= pc_reg;
            out_reg.condition_code  <= sw_reg;
            out_reg.program_ended   <= ended_reg;
            out_reg.read_byte       <= rbyte_reg;
        end
    end

    assign out_data = out_reg;
endmodule

// ===== hw/rtl/sicxe_ctrl.sv =====
// Controller state machine: sequences fetch, address forming, memory beats and execute.
// Depends on sicxe_pkg.
module sicxe_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  logic                   out_stall,
    input  sicxe_pkg::dp_status_t  status,
    output sicxe_pkg::dp_cmd_t     cmd
);
    import sicxe_pkg::*;

    typedef enum logic [20:0] {
        ST_IDLE = 21'h000001,
        ST_DISP = 21'h000002,
        ST_RDB  = 21'h000004,
        ST_F0   = 21'h000008,
        ST_F1   = 21'h000010,
        ST_F2   = 21'h000020,
        ST_F3   = 21'h000040,
        ST_F4   = 21'h000080,
        ST_ADR1 = 21'h000100,
        ST_ADR2 = 21'h000200,
        ST_OPND = 21'h000400,
        ST_R0   = 21'h000800,
        ST_R1   = 21'h001000,
        ST_R2   = 21'h002000,
        ST_R3   = 21'h004000,
        ST_ST0  = 21'h008000,
        ST_ST1  = 21'h010000,
        ST_ST2  = 21'h020000,
        ST_EXEC = 21'h040000,
        ST_ENDC = 21'h080000,
        ST_OUT  = 21'h100000
    } state_t;

    state_t state_reg, state_next;
    logic   ind_reg, ind_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;
    logic   ta_load_reg, ta_load_next;

    assign slot_free = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        ind_next       = ind_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        cmd.asel       = ASEL_ITEM;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.ld_item = 1'b1;
                    state_next  = ST_DISP;
                end
            end
            ST_DISP:
            begin
                case (status.kind)
                    KIND_WRITE:
                    begin
                        cmd.mem_we = 1'b1;
                        state_next = ST_OUT;
                    end
                    KIND_READ: state_next = ST_RDB;
                    KIND_STEP:
                    begin
                        cmd.asel   = ASEL_PC;
                        state_next = ST_F1;
                    end
                    default:   state_next = ST_OUT;
                endcase
            end
            ST_RDB:
            begin
                cmd.cap_rbyte = 1'b1;
                state_next    = ST_OUT;
            end
            ST_F0:
            begin
                cmd.asel   = ASEL_PC;
                state_next = ST_F1;
            end
            ST_F1:
            begin
                cmd.cap_byte = 1'b1;
                cmd.cap_idx  = 2'd0;
                cmd.asel     = ASEL_PC;
                cmd.off      = 2'd1;
                state_next   = ST_F2;
            end
            ST_F2:
            begin
                cmd.cap_byte = 1'b1;
                cmd.cap_idx  = 2'd1;
                cmd.asel     = ASEL_PC;
                cmd.off      = 2'd2;
                state_next   = status.fmt2 ? ST_ADR1 : ST_F3;
            end
            ST_F3:
            begin
                cmd.cap_byte = 1'b1;
                cmd.cap_idx  = 2'd2;
                cmd.ld_npc   = 1'b1;
                cmd.asel     = ASEL_PC;
                cmd.off      = 2'd3;
                state_next   = status.ext ? ST_F4 : ST_ADR1;
            end
            ST_F4:
            begin
                cmd.cap_byte = 1'b1;
                cmd.cap_idx  = 2'd3;
                state_next   = ST_ADR1;
            end
            ST_ADR1:
            begin
                cmd.ld_adr1 = 1'b1;
                state_next  = status.fmt2 ? ST_EXEC : ST_ADR2;
            end
            ST_ADR2:
            begin
                cmd.ld_adr2 = 1'b1;
                if (status.ind)
                begin
                    ind_next   = 1'b1;
                    state_next = ST_R0;
                end
                else
                begin
                    state_next = ST_OPND;
                end
            end
            ST_OPND:
            begin
                // After an indirect fetch the word just read becomes the target.
                cmd.ta_from_word = ta_load_reg;
                if (status.need_word)
                begin
                    state_next = ST_R0;
                end
                else if (status.store3 || status.store1)
                begin
                    state_next = ST_ST0;
                end
                else
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_R0:
            begin
                cmd.asel   = ASEL_TA;
                state_next = ST_R1;
            end
            ST_R1:
            begin
                cmd.shift_word = 1'b1;
                cmd.asel       = ASEL_TA;
                cmd.off        = 2'd1;
                state_next     = ST_R2;
            end
            ST_R2:
            begin
                cmd.shift_word = 1'b1;
                cmd.asel       = ASEL_TA;
                cmd.off        = 2'd2;
                state_next     = ST_R3;
            end
            ST_R3:
            begin
                cmd.shift_word = 1'b1;
                state_next     = ind_reg ? ST_OPND : ST_EXEC;
                // The indirect word becomes the target; OPND then picks the operand access.
                if (ind_reg)
                begin
                    ind_next = 1'b0;
                end
            end
            ST_ST0:
            begin
                cmd.mem_we = 1'b1;
                cmd.asel   = ASEL_TA;
                state_next = status.store1 ? ST_EXEC : ST_ST1;
            end
            ST_ST1:
            begin
                cmd.mem_we = 1'b1;
                cmd.asel   = ASEL_TA;
                cmd.off    = 2'd1;
                state_next = ST_ST2;
            end
            ST_ST2:
            begin
                cmd.mem_we = 1'b1;
                cmd.asel   = ASEL_TA;
                cmd.off    = 2'd2;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                cmd.do_exec = 1'b1;
                state_next  = ST_ENDC;
            end
            ST_ENDC:
            begin
                cmd.do_end = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (slot_free)
                begin
                    cmd.ld_out     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // The last word shift of an indirect read is registered in R3, so the
    // target load is issued in OPND via a registered flag.
    assign ta_load_next = (state_reg == ST_R3) && ind_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ind_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            ta_load_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ind_reg       <= ind_next;
            out_valid_reg <= out_valid_next;
            ta_load_reg   <= ta_load_next;
        end
    end
endmodule

// ===== hw/rtl/sicxe_instruction_executor_top.sv =====
// Top level of the SIC/XE instruction executor: controller plus datapath.
// Depends on sicxe_pkg, sicxe_ctrl and sicxe_dp.
//
// Usage:
// One input beat carries an item: write one memory byte, read one memory
// byte, or execute one instruction at PC. Every item returns exactly one
// result beat with the architectural registers after the item, the
// condition code, the program-ended flag and the byte read (zero otherwise).
// Work on an item is paced by the single-port byte memory, one byte
// per cycle: an instruction step takes up to four fetch beats, three
// indirect beats and three operand beats, a read takes one beat and a
// write one beat, and an unused code none.
// One item is in work at a time; a finished result sits in an output
// register, so the next item is accepted while the receiver stalls, and
// that item completes once the previous result beat is taken.
// Configuration writes (start and end address) are taken any cycle and
// are meant for idle periods. Reset clears the registers, sets the end
// address to all ones and leaves memory undefined until written.
module sicxe_instruction_executor_top (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  sicxe_pkg::in_item_t   in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output sicxe_pkg::out_item_t  out_data,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [19:0]           cfg_data
);
    import sicxe_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    sicxe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    sicxe_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_data  (out_data)
    );
endmodule

// ===== hw/rtl/sicxe_chk.sv =====
// Port-level checker for the SIC/XE instruction executor, bound to the top level.
// Depends on sicxe_pkg.
module sicxe_chk (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_stall,
    input sicxe_pkg::in_item_t   in_data,
    input logic                  out_valid,
    input logic                  out_stall,
    input sicxe_pkg::out_item_t  out_data,
    input logic                  cfg_we,
    input logic                  cfg_index,
    input logic [19:0]           cfg_data
);
    import sicxe_pkg::*;

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    // An accepted item keeps the block busy in the following cycle.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted twice in a row");

    // A program restart clears every register but PC and L.
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.program_ended |->
            out_data.reg_a == '0 && out_data.reg_x == '0 && out_data.reg_b == '0
            && out_data.reg_s == '0 && out_data.reg_t == '0
            && out_data.condition_code == 2'd0)
        else $error("restart left registers set");

    // Only a read returns a byte, and a read never ends the program.
    a_read_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.read_byte != 8'd0 |-> !out_data.program_ended)
        else $error("read byte on an instruction step");

    a_cc_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.condition_code != 2'd3)
        else $error("condition code out of range");
endmodule

bind sicxe_instruction_executor_top sicxe_chk u_chk (.*);

// ===== test/sicxe_tb_pkg.sv =====
// Instruction encodings and condition codes shared by the executor testbench.
// Depends on nothing; the checker and the testbench top import it.
package sicxe_tb_pkg;

    localparam logic [7:0] OP_LDA   = 8'h00;
    localparam logic [7:0] OP_STA   = 8'h0C;
    localparam logic [7:0] OP_STX   = 8'h10;
    localparam logic [7:0] OP_STL   = 8'h14;
    localparam logic [7:0] OP_COMP  = 8'h28;
    localparam logic [7:0] OP_JEQ   = 8'h30;
    localparam logic [7:0] OP_JLT   = 8'h38;
    localparam logic [7:0] OP_J     = 8'h3C;
    localparam logic [7:0] OP_JSUB  = 8'h48;
    localparam logic [7:0] OP_RSUB  = 8'h4C;
    localparam logic [7:0] OP_LDCH  = 8'h50;
    localparam logic [7:0] OP_STCH  = 8'h54;
    localparam logic [7:0] OP_LDB   = 8'h68;
    localparam logic [7:0] OP_LDT   = 8'h74;
    localparam logic [7:0] OP_COMPR = 8'hA0;
    localparam logic [7:0] OP_CLEAR = 8'hB4;
    localparam logic [7:0] OP_TIXR  = 8'hB8;
    localparam logic [7:0] OP_RD    = 8'hD8;
    localparam logic [7:0] OP_TD    = 8'hE0;

    localparam logic [1:0] CC_LESS    = 2'd0;
    localparam logic [1:0] CC_EQUAL   = 2'd1;
    localparam logic [1:0] CC_GREATER = 2'd2;

    // Register file indexes.
    localparam int RI_A  = 0;
    localparam int RI_X  = 1;
    localparam int RI_L  = 2;
    localparam int RI_B  = 3;
    localparam int RI_S  = 4;
    localparam int RI_T  = 5;
    localparam int RI_PC = 8;
    localparam int RI_SW = 9;

    // Role of a memory byte that a step still needs before it may run.
    localparam int ROLE_OPCODE = 0;
    localparam int ROLE_FLAGS  = 1;
    localparam int ROLE_DATA   = 2;

endpackage

// ===== test/sicxe_executor_checker.sv =====
// Checker for the SIC/XE executor: mirrors registers and memory, predicts
// each result beat and compares it. Depends on sicxe_pkg and sicxe_tb_pkg.
module sicxe_executor_checker
    import sicxe_pkg::*;
    import sicxe_tb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  in_item_t    in_data,
    input  logic        out_valid,
    input  logic        out_stall,
    input  out_item_t   out_data,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [19:0] cfg_data,
    output int          fail_count
);

    logic [23:0] gpr [0:9];
    logic [7:0]  mem_image [0:65535];
    bit          mem_valid [0:65535];
    logic [19:0] start_addr;
    logic [19:0] end_addr;
    out_item_t   result_q [$];
    int          end_count;

    initial begin
        fail_count = 0;
        end_count  = 0;
        for (int i = 0; i < 65536; i++) begin
            mem_valid[i] = 1'b0;
            mem_image[i] = 8'h00;
        end
    end

    function automatic logic [7:0] peek(logic [23:0] a);
        return mem_image[a[15:0]];
    endfunction

    function automatic logic [23:0] word_at(logic [23:0] a);
        return {peek(a), peek(a + 24'd1), peek(a + 24'd2)};
    endfunction

    // Returns the first byte of a three-byte word that was never written, or -1.
    function automatic int word_missing(logic [23:0] a);
        for (int i = 0; i < 3; i++) begin
            if (!mem_valid[16'(a + 24'(i))])
                return (ROLE_DATA << 16) | int'(16'(a + 24'(i)));
        end
        return -1;
    endfunction

    function automatic logic [1:0] compare_code(logic [23:0] x, logic [23:0] y);
        return x < y ? CC_LESS : (x == y ? CC_EQUAL : CC_GREATER);
    endfunction

    function automatic logic [23:0] reg_read(logic [3:0] i);
        return i < 10 ? gpr[i] : 24'd0;
    endfunction

    // Register named by the target shifted right by four; a wide target names none.
    function automatic logic [23:0] reg_read_hi(logic [23:0] ta);
        return (ta[23:8] == 16'd0) ? reg_read(ta[7:4]) : 24'd0;
    endfunction

    // Decodes the instruction at PC. Returns -1 when every byte it needs was
    // written, else (role << 16 | address) of the first byte still missing.
    function automatic int decode_at_pc(output logic [7:0] op, output logic [23:0] ta,
                                        output logic [23:0] npc, output logic imm);
        logic [23:0] pc;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [31:0] t;
        int          miss;
        pc  = gpr[RI_PC];
        op  = 8'h00;
        ta  = 24'd0;
        npc = pc;
        imm = 1'b0;
        if (!mem_valid[pc[15:0]])
            return (ROLE_OPCODE << 16) | int'(pc[15:0]);
        b0 = peek(pc);
        if (b0 == OP_COMPR || b0 == OP_CLEAR || b0 == OP_TIXR) begin
            op  = b0;
            npc = pc + 24'd2;
            if (!mem_valid[16'(pc + 24'd1)])
                return (ROLE_DATA << 16) | int'(16'(pc + 24'd1));
            ta = {16'd0, peek(pc + 24'd1)};
            return -1;
        end
        if (!mem_valid[16'(pc + 24'd1)])
            return (ROLE_FLAGS << 16) | int'(16'(pc + 24'd1));
        b1 = peek(pc + 24'd1);
        op = b0 & 8'hFC;
        if (!mem_valid[16'(pc + 24'd2)])
            return (ROLE_DATA << 16) | int'(16'(pc + 24'd2));
        if (b1[4]) begin
            if (!mem_valid[16'(pc + 24'd3)])
                return (ROLE_DATA << 16) | int'(16'(pc + 24'd3));
            npc = pc + 24'd4;
            t   = {12'd0, b1[3:0], peek(pc + 24'd2), peek(pc + 24'd3)};
        end
        else begin
            npc = pc + 24'd3;
            t   = {20'd0, b1[3:0], peek(pc + 24'd2)};
        end
        if (b1[6])
            t = t + gpr[RI_B];
        else if (b1[5]) begin
            // Any field from 0x800 to 0xFFF counts as negative, also in the extended format.
            if ((t >> 11) == 32'd1)
                t = npc - ((t ^ 32'hFFF) + 32'd1);
            else
                t = t + npc;
        end
        ta = t[23:0];
        if (b1[7])
            ta = ta + gpr[RI_X];
        if (b0[1] && !b0[0]) begin
            miss = word_missing(ta);
            if (miss >= 0)
                return miss;
            ta = word_at(ta);
        end
        imm = !b0[1] && b0[0];
        return -1;
    endfunction

    // Used by the stimulus: the next byte that must be written before a step.
    function automatic int step_missing();
        logic [7:0]  op;
        logic [23:0] ta;
        logic [23:0] npc;
        logic        imm;
        int          miss;
        miss = decode_at_pc(op, ta, npc, imm);
        if (miss >= 0 || imm)
            return miss;
        if (op == OP_LDA || op == OP_LDB || op == OP_LDT || op == OP_COMP)
            return word_missing(ta);
        if (op == OP_LDCH && !mem_valid[ta[15:0]])
            return (ROLE_DATA << 16) | int'(ta[15:0]);
        return -1;
    endfunction

    task automatic poke(logic [23:0] a, logic [7:0] v);
        mem_image[a[15:0]] = v;
        mem_valid[a[15:0]] = 1'b1;
    endtask

    task automatic execute_step(output logic ended);
        logic [7:0]  op;
        logic [23:0] ta;
        logic [23:0] npc;
        logic [23:0] v;
        logic        imm;
        int          miss;
        miss = decode_at_pc(op, ta, npc, imm);
        gpr[RI_PC] = npc;
        case (op)
            OP_LDA:  gpr[RI_A] = imm ? ta : word_at(ta);
            OP_LDB:  gpr[RI_B] = imm ? ta : word_at(ta);
            OP_LDT:  gpr[RI_T] = imm ? ta : word_at(ta);
            OP_LDCH: gpr[RI_A][7:0] = imm ? ta[7:0] : peek(ta);
            OP_STA, OP_STX, OP_STL: begin
                v = op == OP_STA ? gpr[RI_A] : (op == OP_STX ? gpr[RI_X] : gpr[RI_L]);
                poke(ta, v[23:16]);
                poke(ta + 24'd1, v[15:8]);
                poke(ta + 24'd2, v[7:0]);
            end
            OP_STCH: poke(ta, gpr[RI_A][7:0]);
            OP_J:    gpr[RI_PC] = ta;
            OP_JSUB: begin
                gpr[RI_L]  = gpr[RI_PC];
                gpr[RI_PC] = ta;
            end
            OP_JLT:  if (gpr[RI_SW] == 24'(CC_LESS)) gpr[RI_PC] = ta;
            OP_JEQ:  if (gpr[RI_SW] == 24'(CC_EQUAL)) gpr[RI_PC] = ta;
            OP_RSUB: gpr[RI_PC] = gpr[RI_L];
            OP_COMP: gpr[RI_SW] = 24'(compare_code(gpr[RI_A], imm ? ta : word_at(ta)));
            OP_COMPR: gpr[RI_SW] = 24'(compare_code(reg_read_hi(ta), reg_read(ta[3:0])));
            OP_CLEAR: if (ta[23:8] == 16'd0 && ta[7:4] < 10) gpr[ta[7:4]] = 24'd0;
            OP_TIXR: begin
                gpr[RI_X]  = gpr[RI_X] + 24'd1;
                gpr[RI_SW] = 24'(compare_code(gpr[RI_X], reg_read_hi(ta)));
            end
            OP_TD:   gpr[RI_SW] = 24'(CC_LESS);
            OP_RD:   gpr[RI_A] = gpr[RI_A] >> 8;
            default: ;
        endcase
        ended = gpr[RI_PC] == {4'd0, end_addr};
        if (ended) begin
            for (int i = 0; i < 10; i++)
                gpr[i] = 24'd0;
            gpr[RI_PC] = {4'd0, start_addr};
            gpr[RI_L]  = {4'd0, end_addr};
        end
    endtask

    task automatic predict_result(input in_item_t item, output out_item_t res);
        logic       ended;
        logic [7:0] rbyte;
        ended = 1'b0;
        rbyte = 8'h00;
        case (item.opcode)
            KIND_WRITE: poke({8'd0, item.mem_address}, item.write_byte);
            KIND_READ:  rbyte = mem_image[item.mem_address];
            KIND_STEP:  execute_step(ended);
            default: ;
        endcase
        if (ended)
            end_count++;
        res.reg_a           = gpr[RI_A];
        res.reg_x           = gpr[RI_X];
        res.reg_l           = gpr[RI_L];
        res.reg_b           = gpr[RI_B];
        res.reg_s           = gpr[RI_S];
        res.reg_t           = gpr[RI_T];
        res.program_counter = gpr[RI_PC];
        res.condition_code  = gpr[RI_SW][1:0];
        res.program_ended   = ended;
        res.read_byte       = rbyte;
    endtask

    task automatic check_field(string name, logic [23:0] exp_v, logic [23:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        out_item_t exp_r;
        out_item_t new_r;
        if (!rst_n) begin
            for (int i = 0; i < 10; i++)
                gpr[i] = 24'd0;
            start_addr = 20'd0;
            end_addr   = 20'hFFFFF;
        end
        else begin
            if (out_valid && !out_stall) begin
                if (result_q.size() == 0) begin
                    $error("result beat with no expected result pending");
                    fail_count++;
                end
                else begin
                    exp_r = result_q.pop_front();
                    check_field("reg_a", exp_r.reg_a, out_data.reg_a);
                    check_field("reg_x", exp_r.reg_x, out_data.reg_x);
                    check_field("reg_l", exp_r.reg_l, out_data.reg_l);
                    check_field("reg_b", exp_r.reg_b, out_data.reg_b);
                    check_field("reg_s", exp_r.reg_s, out_data.reg_s);
                    check_field("reg_t", exp_r.reg_t, out_data.reg_t);
                    check_field("program_counter", exp_r.program_counter,
                                out_data.program_counter);
                    check_field("condition_code", 24'(exp_r.condition_code),
                                24'(out_data.condition_code));
                    check_field("program_ended", 24'(exp_r.program_ended),
                                24'(out_data.program_ended));
                    check_field("read_byte", 24'(exp_r.read_byte), 24'(out_data.read_byte));
                end
            end
            if (in_valid && !in_stall) begin
                predict_result(in_data, new_r);
                result_q.push_back(new_r);
            end
            if (cfg_we) begin
                if (cfg_index == CFG_START)
                    start_addr = cfg_data;
                else
                    end_addr = cfg_data;
            end
        end
    end

endmodule

// ===== test/sicxe_instruction_executor_top_tb.sv =====
// Testbench top for the SIC/XE executor: drives items, configuration and result stalls.
// Depends on sicxe_pkg, sicxe_tb_pkg, the executor top and sicxe_executor_checker.
module sicxe_instruction_executor_top_tb;
    import sicxe_pkg::*;
    import sicxe_tb_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_stall;
    out_item_t   out_data;
    logic        cfg_we;
    logic        cfg_index;
    logic [19:0] cfg_data;
    int          fail_count;
    int          cycle_count;
    int          item_count;
    int          step_count;
    int          phase_count;

    sicxe_instruction_executor_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sicxe_executor_checker u_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Receiver stalls: runs of random length, mostly short, now and then long.
    initial begin
        int hold;
        out_stall = 1'b0;
        hold      = 0;
        forever begin
            @(negedge clk);
            if (hold == 0) begin
                if ($urandom_range(0, 1) == 0) begin
                    out_stall <= 1'b0;
                    hold = $urandom_range(1, 30);
                end
                else begin
                    out_stall <= 1'b1;
                    hold = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                        : $urandom_range(1, 3);
                end
            end
            else
                hold--;
        end
    end

    // Presents one beat; called and returning at a falling edge.
    task automatic send_item(logic [1:0] kind, logic [15:0] addr, logic [7:0] data);
        int r;
        in_item_t item;
        item.opcode      = kind;
        item.mem_address = addr;
        item.write_byte  = data;
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        item_count++;
        r = $urandom_range(0, 99);
        if (r >= 55) begin
            in_valid <= 1'b0;
            repeat (r < 90 ? $urandom_range(1, 3) : $urandom_range(10, 40))
                @(negedge clk);
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (u_chk.result_q.size() != 0)
            @(negedge clk);
        // Every expected result has been taken by now; the wait below adds margin.
        repeat (30) @(negedge clk);
    endtask

    task automatic write_config(logic idx, logic [19:0] value);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        phase_count++;
    endtask

    function automatic logic [7:0] pick_opcode();
        logic [7:0] base;
        logic [1:0] ni;
        if ($urandom_range(0, 9) < 2)
            return 8'($urandom);
        case ($urandom_range(0, 18))
            0:  base = OP_LDA;
            1:  base = OP_LDB;
            2:  base = OP_LDT;
            3:  base = OP_LDCH;
            4:  base = OP_STA;
            5:  base = OP_STX;
            6:  base = OP_STL;
            7:  base = OP_STCH;
            8:  base = OP_J;
            9:  base = OP_JSUB;
            10: base = OP_JLT;
            11: base = OP_JEQ;
            12: base = OP_RSUB;
            13: base = OP_COMP;
            14: return OP_COMPR;
            15: return OP_CLEAR;
            16: return OP_TIXR;
            17: base = OP_TD;
            default: base = OP_RD;
        endcase
        ni = ($urandom_range(0, 9) < 6) ? 2'b11 : 2'($urandom);
        return base | {6'd0, ni};
    endfunction

    function automatic logic [7:0] pick_flags();
        logic [7:0] f;
        f      = 8'($urandom);
        f[7]   = $urandom_range(0, 4) == 0;
        f[6]   = $urandom_range(0, 6) == 0;
        f[5]   = $urandom_range(0, 4) < 2;
        f[4]   = $urandom_range(0, 3) == 0;
        return f;
    endfunction

    // Fills every byte the step at PC will read, then runs it. A forced
    // opcode byte, when given, is placed at PC first.
    task automatic run_step(int forced_op);
        int miss;
        logic [15:0] a;
        logic [7:0]  v;
        if (forced_op >= 0)
            send_item(KIND_WRITE, u_chk.gpr[RI_PC][15:0], 8'(forced_op));
        miss = u_chk.step_missing();
        while (miss >= 0) begin
            a = 16'(miss);
            case (miss >> 16)
                ROLE_OPCODE: v = pick_opcode();
                ROLE_FLAGS:  v = pick_flags();
                default:     v = 8'($urandom);
            endcase
            send_item(KIND_WRITE, a, v);
            miss = u_chk.step_missing();
        end
        send_item(KIND_STEP, 16'($urandom), 8'($urandom));
        step_count++;
    endtask

    task automatic read_byte_at(logic [15:0] a);
        if (!u_chk.mem_valid[a])
            send_item(KIND_WRITE, a, 8'($urandom));
        send_item(KIND_READ, a, 8'($urandom));
    endtask

    // Sets the end address two bytes past PC and runs a CLEAR to land there unless it clears PC.
    task automatic force_program_end(logic [19:0] new_start);
        write_config(CFG_START, new_start);
        write_config(CFG_END, 20'(u_chk.gpr[RI_PC] + 24'd2));
        run_step(OP_CLEAR);
    endtask

    initial begin
        int r;
        logic [7:0] directed_ops [$];
        directed_ops = '{OP_LDA | 8'h3, OP_LDB | 8'h1, OP_LDT | 8'h2, OP_LDCH | 8'h3,
                         OP_LDCH | 8'h1, OP_STA | 8'h3, OP_STX | 8'h1, OP_STL | 8'h3,
                         OP_STCH | 8'h2, OP_COMP | 8'h3, OP_COMPR, OP_CLEAR, OP_TIXR,
                         OP_COMPR | 8'h1, OP_CLEAR | 8'h3, OP_TIXR | 8'h2, OP_TD | 8'h3,
                         OP_RD | 8'h3, OP_JLT | 8'h3, OP_JEQ | 8'h3, OP_JSUB | 8'h3,
                         OP_RSUB | 8'h3, OP_J | 8'h0, 8'hF4};
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        cfg_we      = 1'b0;
        cfg_index   = CFG_START;
        cfg_data    = 20'd0;
        cycle_count = 0;
        item_count  = 0;
        step_count  = 0;
        phase_count = 0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: field extremes, the unused code, then every instruction.
        send_item(KIND_WRITE, 16'h0000, 8'hFF);
        send_item(KIND_WRITE, 16'hFFFF, 8'h00);
        send_item(KIND_READ, 16'hFFFF, 8'hFF);
        send_item(KIND_READ, 16'h0000, 8'h00);
        send_item(2'd3, 16'hFFFF, 8'hFF);
        send_item(2'd3, 16'h0000, 8'h00);
        foreach (directed_ops[i])
            run_step(int'(directed_ops[i]));
        force_program_end(20'hFFFFF);
        force_program_end(20'h00000);
        write_config(CFG_END, 20'hFFFFF);

        while (item_count < 1800) begin
            r = $urandom_range(0, 99);
            if (r < 72)
                run_step(-1);
            else if (r < 82)
                send_item(KIND_WRITE, 16'($urandom), 8'($urandom));
            else if (r < 93)
                read_byte_at(16'($urandom));
            else if (r < 96)
                send_item(2'd3, 16'($urandom), 8'($urandom));
            else if (r < 98)
                force_program_end(($urandom_range(0, 3) == 0) ? 20'hFFFFF
                                                               : 20'($urandom));
            else begin
                // Let everything drain before going on.
                wait_idle();
                write_config(CFG_END, ($urandom_range(0, 1) == 0) ? 20'd0
                                                                   : 20'($urandom));
            end
        end

        in_valid <= 1'b0;
        while (u_chk.result_q.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
        $display("Ran %0d items, %0d of them instruction steps, over %0d configuration writes.",
                 item_count, step_count, phase_count);
        $display("Program end was reached %0d times.", u_chk.end_count);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/sicxe_pkg.sv
hw/rtl/sicxe_ram.sv
hw/rtl/sicxe_dp.sv
hw/rtl/sicxe_ctrl.sv
hw/rtl/sicxe_instruction_executor_top.sv
hw/rtl/sicxe_chk.sv
test/sicxe_tb_pkg.sv
test/sicxe_executor_checker.sv
test/sicxe_instruction_executor_top_tb.sv
